[src/mbdq_pkg.sv]
package mbdq_pkg;

   localparam int DIMS                = 3;
   localparam int TABLE_DEPTH_DEFAULT = 1024;

   localparam int COORD_W = 16;
   localparam int KEY_W   = 3 * COORD_W;
   localparam int COUNT_W = 24;
   localparam int ENTRY_W = KEY_W + COUNT_W;

   localparam logic [3:0] CSR_DIMS_USED   = 4'd0;
   localparam logic [3:0] CSR_ORIGIN_X    = 4'd1;
   localparam logic [3:0] CSR_ORIGIN_Y    = 4'd2;
   localparam logic [3:0] CSR_ORIGIN_Z    = 4'd3;
   localparam logic [3:0] CSR_INV_WIDTH_X = 4'd4;
   localparam logic [3:0] CSR_INV_WIDTH_Y = 4'd5;
   localparam logic [3:0] CSR_INV_WIDTH_Z = 4'd6;
   localparam logic [3:0] CSR_INV_NORM    = 4'd7;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [1:0] STATUS_QUERY_DONE = 2'd0;
   localparam logic [1:0] STATUS_ADDED      = 2'd1;
   localparam logic [1:0] STATUS_OVERWRITE  = 2'd2;
   localparam logic [1:0] STATUS_FULL       = 2'd3;

   localparam logic [1:0]  RESET_DIMS      = 2'd3;
   localparam logic [31:0] RESET_INV_WIDTH = 32'd65536;
   localparam logic [47:0] RESET_INV_NORM  = 48'h0001_0000_0000;

   typedef struct packed {
      logic               req_type;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [15:0] cell_x;
      logic signed [15:0] cell_y;
      logic signed [15:0] cell_z;
      logic [23:0]        cell_count;
   } mbdq_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [47:0] density;
      logic [3:0]  corners_hit;
   } mbdq_rsp_type;

   typedef struct packed {
      logic [3:0]  index;
      logic [47:0] data;
   } mbdq_csr_type;

endpackage

[src/mbdq_chan_if.sv]
interface mbdq_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[src/mbdq_cell_table.sv]
module mbdq_cell_table
   import mbdq_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output logic [ENTRY_W-1:0]             rd_data,
   input  logic                           wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  logic [ENTRY_W-1:0]             wr_data
);

   logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[src/multilinear_binned_density_query.sv]
// Multilinear binned density query. A load request stores one occupied grid cell
// (its three 16-bit cell indices and a 24-bit count) in an on-chip table of
// TABLE_DEPTH entries; loading a cell that is already present overwrites its
// count, and a new cell arriving at a full table is dropped with a full status.
// A query request scales the point into a cell index and a Q0.16 fraction per
// active dimension, looks up the 2^d surrounding corner cells, and returns the
// sum of corner weight times count, scaled by inv_norm and saturated to 48 bits,
// together with the number of corners found with a nonzero count. The table is
// searched linearly through its single read port, one entry per cycle, and all
// multiplications go through one shared 34 by 34 bit multiplier. The block
// takes one request at a time; a finished response waits in the output register
// while the next request is accepted. Configuration writes are taken at any
// time but must only be issued while the block is idle. The table needs no
// clearing after reset: only entries below the fill count are ever read.
module multilinear_binned_density_query
   import mbdq_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input logic  clock,
   input logic  reset,
   mbdq_chan_if.sink   req_ch,
   mbdq_chan_if.source rsp_ch,
   mbdq_chan_if.sink   csr_ch
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SC_MUL, ST_SC_FIX, ST_KEYS, ST_SCAN, ST_LOAD_WR,
      ST_W1, ST_W2, ST_W3, ST_WACC, ST_FMUL, ST_FADD, ST_OUT
   } state_type;

   // Configuration registers.
   logic [1:0]         dims_ff;
   logic signed [31:0] origin_ff [3];
   logic [31:0]        inv_width_ff [3];
   logic [47:0]        inv_norm_ff;

   state_type          state_ff;
   mbdq_req_type       req_ff;
   logic [1:0]         dim_ff;
   logic signed [34:0] kval_ff [3];
   logic [15:0]        frac_ff [3];
   logic [KEY_W-1:0]   ckey_ff [8];
   logic [7:0]         cok_ff;
   logic [7:0]         chit_ff;
   logic [COUNT_W-1:0] ccnt_ff [8];
   logic [2:0]         corner_ff;
   logic [FILL_W-1:0]  scan_idx_ff;
   logic               pend_ff;
   logic               match_ff;
   logic [ADDR_W-1:0]  match_idx_ff;
   logic [ADDR_W-1:0]  pend_idx_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic [67:0]        prod_ff;
   logic [59:0]        acc_ff;
   logic [107:0]       big_ff;
   logic [1:0]         pp_ff;
   logic [3:0]         hits_ff;
   logic [1:0]         status_ff;
   logic               rsp_valid_ff;
   mbdq_rsp_type       rsp_data_ff;

   logic [1:0]         d_act;
   logic               rd_en;
   logic [ENTRY_W-1:0] rd_data;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [KEY_W-1:0]   load_key;
   logic [33:0]        mul_a;
   logic [33:0]        mul_b;
   logic [67:0]        mul_p;
   logic [16:0]        fac [3];
   logic [32:0]        rounded_w;
   logic signed [32:0] diff;
   logic [31:0]        mag;
   logic [48:0]        neg_q;
   logic [49:0]        neg_t;
   logic signed [34:0] fix_k;
   logic [15:0]        fix_u;
   logic [KEY_W-1:0]   corner_key [8];
   logic [7:0]         corner_ok;
   logic signed [31:0] point_sel;
   logic [FILL_W-1:0]  depth_full;

   assign depth_full = FILL_W'(TABLE_DEPTH);

   // Active dimension count: zero acts as one, limited to what the key holds.
   always_comb begin
      d_act = dims_ff;
      if (d_act == 2'd0) begin
         d_act = 2'd1;
      end
      if (32'(d_act) > DIMS) begin
         d_act = 2'(DIMS);
      end
   end

   // Key of a load: coordinates of inactive dimensions are kept as zero.
   always_comb begin
      load_key = {16'(req_ff.cell_z), 16'(req_ff.cell_y), 16'(req_ff.cell_x)};
      if (d_act < 2'd3) begin
         load_key[47:32] = '0;
      end
      if (d_act < 2'd2) begin
         load_key[31:16] = '0;
      end
   end

   // Coordinate scaling: magnitude of point minus origin for the current dimension.
   always_comb begin
      unique case (dim_ff)
         2'd0:    point_sel = req_ff.point_x;
         2'd1:    point_sel = req_ff.point_y;
         default: point_sel = req_ff.point_z;
      endcase
      diff = 33'(point_sel) - 33'(origin_ff[dim_ff]);
      mag  = diff[32] ? 32'(-diff) : diff[31:0];
   end

   // Floor of the scaled coordinate. A negative value rounds its magnitude up so
   // that the cell index and the fraction describe the floor.
   always_comb begin
      neg_q = {1'b0, prod_ff[63:16]} + 49'(prod_ff[15:0] != 16'd0);
      neg_t = {1'b0, neg_q} + 50'd65535;
      if (32'(dim_ff) >= 32'(d_act)) begin
         fix_k = '0;
         fix_u = '0;
      end else if (diff[32]) begin
         fix_k = -$signed({1'b0, neg_t[49:16]});
         fix_u = 16'(17'h10000 - {1'b0, neg_q[15:0]});
      end else begin
         fix_k = $signed({3'b000, prod_ff[63:32]});
         fix_u = prod_ff[31:16];
      end
   end

   // Corner keys and range checks, all eight corners side by side.
   always_comb begin
      logic signed [34:0] c;
      logic               in_range;
      for (int m = 0; m < 8; m++) begin
         in_range = 1'b1;
         corner_key[m] = '0;
         for (int s = 0; s < 3; s++) begin
            c = kval_ff[s] + 35'(m[s]);
            if (c < -35'sd32768 || c > 35'sd32767) begin
               in_range = 1'b0;
            end
            corner_key[m][16*s +: 16] = c[15:0];
         end
         corner_ok[m] = in_range && (m < (1 << d_act));
      end
   end

   // Corner factors: u for a set bit, one minus u for a clear bit, and one for an
   // inactive dimension, which stands for the alignment to Q0.48.
   always_comb begin
      for (int s = 0; s < 3; s++) begin
         if (32'(s) >= 32'(d_act)) begin
            fac[s] = 17'h10000;
         end else if (corner_ff[s]) begin
            fac[s] = {1'b0, frac_ff[s]};
         end else begin
            fac[s] = 17'h10000 - {1'b0, frac_ff[s]};
         end
      end
   end

   assign rounded_w = 33'((prod_ff[48:0] + 49'h8000) >> 16);

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SC_MUL: begin
            mul_a = 34'(mag);
            mul_b = 34'(inv_width_ff[dim_ff]);
         end
         ST_W1: begin
            mul_a = 34'(fac[0]);
            mul_b = 34'(fac[1]);
         end
         ST_W2: begin
            mul_a = prod_ff[33:0];
            mul_b = 34'(fac[2]);
         end
         ST_W3: begin
            mul_a = 34'(rounded_w);
            mul_b = 34'(ccnt_ff[corner_ff]);
         end
         ST_FMUL: begin
            mul_a = pp_ff[1] ? 34'(acc_ff[59:32]) : 34'(acc_ff[31:0]);
            mul_b = pp_ff[0] ? 34'(inv_norm_ff[47:32]) : 34'(inv_norm_ff[31:0]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Table access: linear search while scanning, at most one write as a load ends.
   assign rd_en   = (state_ff == ST_SCAN) && (scan_idx_ff < fill_ff);
   assign wr_en   = (state_ff == ST_LOAD_WR) && (match_ff || fill_ff < depth_full);
   assign wr_addr = match_ff ? match_idx_ff : fill_ff[ADDR_W-1:0];

   mbdq_cell_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (scan_idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({load_key, req_ff.cell_count})
   );

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign csr_ch.ready    = 1'b1;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.payload  = rsp_data_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff      <= RESET_DIMS;
         origin_ff    <= '{default: '0};
         inv_width_ff <= '{default: RESET_INV_WIDTH};
         inv_norm_ff  <= RESET_INV_NORM;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.payload.index)
            CSR_DIMS_USED:   dims_ff         <= csr_ch.payload.data[1:0];
            CSR_ORIGIN_X:    origin_ff[0]    <= csr_ch.payload.data[31:0];
            CSR_ORIGIN_Y:    origin_ff[1]    <= csr_ch.payload.data[31:0];
            CSR_ORIGIN_Z:    origin_ff[2]    <= csr_ch.payload.data[31:0];
            CSR_INV_WIDTH_X: inv_width_ff[0] <= csr_ch.payload.data[31:0];
            CSR_INV_WIDTH_Y: inv_width_ff[1] <= csr_ch.payload.data[31:0];
            CSR_INV_WIDTH_Z: inv_width_ff[2] <= csr_ch.payload.data[31:0];
            CSR_INV_NORM:    inv_norm_ff     <= csr_ch.payload.data;
            default:         ;
         endcase
      end
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         // The output register loads a new response once the old one is gone.
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ch.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  req_ff      <= req_ch.payload;
                  hits_ff     <= '0;
                  big_ff      <= '0;
                  match_ff    <= 1'b0;
                  dim_ff      <= '0;
                  scan_idx_ff <= '0;
                  pend_ff     <= 1'b0;
                  state_ff    <= (req_ch.payload.req_type == REQ_QUERY) ? ST_SC_MUL : ST_SCAN;
               end
            end
            ST_SC_MUL: begin
               prod_ff  <= mul_p;
               state_ff <= ST_SC_FIX;
            end
            ST_SC_FIX: begin
               kval_ff[dim_ff] <= fix_k;
               frac_ff[dim_ff] <= fix_u;
               if (dim_ff == 2'd2) begin
                  state_ff <= ST_KEYS;
               end else begin
                  dim_ff   <= dim_ff + 2'd1;
                  state_ff <= ST_SC_MUL;
               end
            end
            ST_KEYS: begin
               ckey_ff  <= corner_key;
               cok_ff   <= corner_ok;
               chit_ff  <= '0;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               pend_ff <= rd_en;
               if (rd_en) begin
                  scan_idx_ff <= scan_idx_ff + FILL_W'(1);
                  pend_idx_ff <= scan_idx_ff[ADDR_W-1:0];
               end
               if (pend_ff) begin
                  if (req_ff.req_type == REQ_LOAD) begin
                     if (rd_data[ENTRY_W-1:COUNT_W] == load_key) begin
                        match_ff     <= 1'b1;
                        match_idx_ff <= pend_idx_ff;
                     end
                  end else begin
                     for (int m = 0; m < 8; m++) begin
                        if (cok_ff[m] && rd_data[ENTRY_W-1:COUNT_W] == ckey_ff[m]) begin
                           chit_ff[m] <= 1'b1;
                           ccnt_ff[m] <= rd_data[COUNT_W-1:0];
                        end
                     end
                  end
               end
               if (!rd_en && !pend_ff) begin
                  corner_ff <= '0;
                  acc_ff    <= '0;
                  state_ff  <= (req_ff.req_type == REQ_LOAD) ? ST_LOAD_WR : ST_W1;
               end
            end
            ST_LOAD_WR: begin
               if (match_ff) begin
                  status_ff <= STATUS_OVERWRITE;
               end else if (fill_ff < depth_full) begin
                  status_ff <= STATUS_ADDED;
                  fill_ff   <= fill_ff + FILL_W'(1);
               end else begin
                  status_ff <= STATUS_FULL;
               end
               state_ff <= ST_OUT;
            end
            ST_W1: begin
               if (chit_ff[corner_ff] && ccnt_ff[corner_ff] != '0) begin
                  prod_ff  <= mul_p;
                  state_ff <= ST_W2;
               end else if (corner_ff == 3'd7) begin
                  pp_ff    <= '0;
                  state_ff <= ST_FMUL;
               end else begin
                  corner_ff <= corner_ff + 3'd1;
               end
            end
            ST_W2: begin
               prod_ff  <= mul_p;
               state_ff <= ST_W3;
            end
            ST_W3: begin
               prod_ff  <= mul_p;
               state_ff <= ST_WACC;
            end
            ST_WACC: begin
               acc_ff  <= acc_ff + 60'(prod_ff[56:0]);
               hits_ff <= hits_ff + 4'd1;
               if (corner_ff == 3'd7) begin
                  pp_ff    <= '0;
                  state_ff <= ST_FMUL;
               end else begin
                  corner_ff <= corner_ff + 3'd1;
                  state_ff  <= ST_W1;
               end
            end
            ST_FMUL: begin
               prod_ff  <= mul_p;
               state_ff <= ST_FADD;
            end
            ST_FADD: begin
               // Partial products sit at 0, 32, 32 and 64 bits.
               big_ff <= big_ff + ((108'(prod_ff)) << (7'd32 * 7'({1'b0, pp_ff[1]}
                                   + {1'b0, pp_ff[0]})));
               if (pp_ff == 2'd3) begin
                  status_ff <= STATUS_QUERY_DONE;
                  state_ff  <= ST_OUT;
               end else begin
                  pp_ff    <= pp_ff + 2'd1;
                  state_ff <= ST_FMUL;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_data_ff.status      <= status_ff;
                  rsp_data_ff.density     <= (big_ff[107:80] != '0) ? '1 : big_ff[79:32];
                  rsp_data_ff.corners_hit <= hits_ff;
                  state_ff                <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // The fill count never passes the table depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= depth_full)
      else $error("fill count beyond table depth");

   // A read never reaches an entry that was not yet written.
   a_read_filled: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (scan_idx_ff < fill_ff))
      else $error("table read beyond fill count");

   // A new response appears only out of the output state.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside output state");

   // The table is never written and read in the same cycle.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("table read and write collide");

endmodule

[bench/multilinear_binned_density_query_test.sv]
`timescale 1ns / 1ps

module multilinear_binned_density_query_test;
   import mbdq_pkg::*;

   localparam int TABLE_ENTRIES = TABLE_DEPTH_DEFAULT;
   // Generous ceiling: a full table makes every request walk 1024 entries.
   localparam longint CYCLE_LIMIT = 6000000;

   // Running model of the density table and its registers, together with the
   // queue of responses that the block still owes.
   class density_scoreboard;
      logic [1:0]           dims_reg;
      longint               origin[3];
      longint unsigned      inv_width[3];
      logic [47:0]          inv_norm;
      logic [47:0]          key_tab[TABLE_ENTRIES];
      logic [23:0]          count_tab[TABLE_ENTRIES];
      int                   fill;
      mbdq_rsp_type         owed[$];
      int                   mismatches;

      function new();
         dims_reg = RESET_DIMS;
         for (int s = 0; s < 3; s++) begin
            origin[s] = 0;
            inv_width[s] = RESET_INV_WIDTH;
         end
         inv_norm = RESET_INV_NORM;
         fill = 0;
         mismatches = 0;
      endfunction

      function void set_register(logic [3:0] index, logic [47:0] data);
         case (index)
            CSR_DIMS_USED:   dims_reg = data[1:0];
            CSR_ORIGIN_X:    origin[0] = longint'($signed(data[31:0]));
            CSR_ORIGIN_Y:    origin[1] = longint'($signed(data[31:0]));
            CSR_ORIGIN_Z:    origin[2] = longint'($signed(data[31:0]));
            CSR_INV_WIDTH_X: inv_width[0] = data[31:0];
            CSR_INV_WIDTH_Y: inv_width[1] = data[31:0];
            CSR_INV_WIDTH_Z: inv_width[2] = data[31:0];
            CSR_INV_NORM:    inv_norm = data;
            default: ;
         endcase
      endfunction

      function int active_dims();
         return (dims_reg == 0) ? 1 : int'(dims_reg);
      endfunction

      function int find_cell(logic [47:0] key);
         for (int i = 0; i < fill; i++)
            if (key_tab[i] == key) return i;
         return -1;
      endfunction

      // Floor of (p - o) * w in Q.16, split into cell index and fraction.
      function void scale_axis(longint p, longint o, longint unsigned w,
                               output longint k, output int unsigned u);
         longint diff;
         longint unsigned mag, m, q;
         diff = p - o;
         mag = (diff < 0) ? longint'(-diff) : diff;
         m = mag * w;
         q = m >> 16;
         if (diff >= 0) begin
            k = longint'(q >> 16);
            u = 32'(q[15:0]);
         end else begin
            if (m[15:0] != 0) q = q + 1;
            k = -longint'((q + 64'hFFFF) >> 16);
            u = (32'd65536 - {16'd0, q[15:0]}) & 32'hFFFF;
         end
      endfunction

      function void note_request(mbdq_req_type r);
         mbdq_rsp_type e;
         int d, at;
         logic [47:0] key;
         longint k[3];
         int unsigned u[3];
         logic [63:0] acc;
         logic [127:0] prod;
         d = active_dims();
         e = '0;
         if (r.req_type == REQ_LOAD) begin
            key = '0;
            key[15:0] = r.cell_x;
            if (d > 1) key[31:16] = r.cell_y;
            if (d > 2) key[47:32] = r.cell_z;
            at = find_cell(key);
            if (at >= 0) begin
               count_tab[at] = r.cell_count;
               e.status = STATUS_OVERWRITE;
            end else if (fill < TABLE_ENTRIES) begin
               key_tab[fill] = key;
               count_tab[fill] = r.cell_count;
               fill++;
               e.status = STATUS_ADDED;
            end else begin
               e.status = STATUS_FULL;
            end
         end else begin
            k = '{0, 0, 0};
            u = '{0, 0, 0};
            scale_axis(longint'(r.point_x), origin[0], inv_width[0], k[0], u[0]);
            if (d > 1) scale_axis(longint'(r.point_y), origin[1], inv_width[1], k[1], u[1]);
            if (d > 2) scale_axis(longint'(r.point_z), origin[2], inv_width[2], k[2], u[2]);
            acc = 0;
            for (int corner = 0; corner < (1 << d); corner++) begin
               logic [63:0] w;
               bit outside;
               w = 1;
               key = '0;
               outside = 0;
               for (int s = 0; s < d; s++) begin
                  longint c;
                  c = k[s] + ((corner >> s) & 1);
                  w = w * (((corner >> s) & 1) ? u[s] : (65536 - u[s]));
                  if (c < -32768 || c > 32767) outside = 1;
                  key[16*s +: 16] = c[15:0];
               end
               if (outside) continue;
               w = w << (16 * (3 - d));
               w = (w + 64'h8000) >> 16;
               at = find_cell(key);
               if (at >= 0 && count_tab[at] != 0) begin
                  e.corners_hit = e.corners_hit + 4'd1;
                  acc = acc + w * count_tab[at];
               end
            end
            prod = (128'(acc) * 128'(inv_norm)) >> 32;
            e.status = STATUS_QUERY_DONE;
            e.density = (prod >= 128'h1_0000_0000_0000) ? 48'hFFFF_FFFF_FFFF : prod[47:0];
         end
         owed.push_back(e);
      endfunction

      task report_mismatch(string what, longint unsigned got, longint unsigned want);
         $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
         mismatches++;
      endtask

      task check_response(mbdq_rsp_type got);
         mbdq_rsp_type want;
         if (owed.size() == 0) begin
            report_mismatch("unexpected response, status", got.status, 0);
            return;
         end
         want = owed.pop_front();
         if (got.status !== want.status) report_mismatch("status", got.status, want.status);
         if (got.density !== want.density) report_mismatch("density", got.density, want.density);
         if (got.corners_hit !== want.corners_hit)
            report_mismatch("corners_hit", got.corners_hit, want.corners_hit);
      endtask
   endclass

   logic clock;
   logic reset;
   longint cycles;
   // While set, neither side inserts idle cycles or stalls.
   bit steady;
   density_scoreboard board;

   mbdq_chan_if #(.payload_type(mbdq_req_type)) req_ch ();
   mbdq_chan_if #(.payload_type(mbdq_rsp_type)) rsp_ch ();
   mbdq_chan_if #(.payload_type(mbdq_csr_type)) csr_ch ();

   multilinear_binned_density_query uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // The watchdog counts every cycle and gives up long after the slowest
   // correct run would have finished.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** multilinear_binned_density_query: FAILED **");
         $finish;
      end
   end

   // The response side checks whatever was handed over at this edge, then
   // picks its ready for the next cycle, stalling about a quarter of the time.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) board.check_response(rsp_ch.payload);
         rsp_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 26);
      end
   end

   // Present one request and hold it until the block takes it. The optional
   // gap in front lowers valid at each of its edges, so valid never gets two updates per edge.
   task automatic send_request(input mbdq_req_type r);
      if (!steady) begin
         while ($urandom_range(99) < 26) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(r);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (board.owed.size() != 0) @(posedge clock);
   endtask

   // Registers are only touched once every owed response has come back.
   task automatic write_register(input logic [3:0] index, input logic [47:0] data);
      mbdq_csr_type w;
      wait_drained();
      w.index = index;
      w.data = data;
      csr_ch.valid <= 1'b1;
      csr_ch.payload <= w;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      board.set_register(index, data);
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [1:0] dims, input logic [31:0] ox, oy, oz,
                                input logic [31:0] wx, wy, wz, input logic [47:0] norm);
      write_register(CSR_DIMS_USED, {46'd0, dims});
      write_register(CSR_ORIGIN_X, {16'd0, ox});
      write_register(CSR_ORIGIN_Y, {16'd0, oy});
      write_register(CSR_ORIGIN_Z, {16'd0, oz});
      write_register(CSR_INV_WIDTH_X, {16'd0, wx});
      write_register(CSR_INV_WIDTH_Y, {16'd0, wy});
      write_register(CSR_INV_WIDTH_Z, {16'd0, wz});
      write_register(CSR_INV_NORM, norm);
   endtask

   task automatic load_cell(input int cx, cy, cz, input int unsigned count);
      mbdq_req_type r;
      r = '0;
      r.req_type = REQ_LOAD;
      r.point_x = $urandom;
      r.cell_x = 16'(cx);
      r.cell_y = 16'(cy);
      r.cell_z = 16'(cz);
      r.cell_count = 24'(count);
      send_request(r);
   endtask

   task automatic query_point(input logic [31:0] px, py, pz);
      mbdq_req_type r;
      r = '0;
      r.req_type = REQ_QUERY;
      r.point_x = px;
      r.point_y = py;
      r.point_z = pz;
      r.cell_x = 16'($urandom);
      send_request(r);
   endtask

   // Random requests stay mostly inside a small neighborhood of cells so that
   // queries find loaded corners and the table stays short. Every field is
   // filled at random first, so idle fields still exercise all of their bits.
   function automatic mbdq_req_type random_request();
      mbdq_req_type r;
      int roll;
      r.req_type = ($urandom_range(99) < 40) ? REQ_LOAD : REQ_QUERY;
      r.point_x = $urandom;
      r.point_y = $urandom;
      r.point_z = $urandom;
      r.cell_x = 16'($urandom);
      r.cell_y = 16'($urandom);
      r.cell_z = 16'($urandom);
      r.cell_count = 24'($urandom);
      roll = $urandom_range(99);
      if (r.req_type == REQ_LOAD) begin
         if (roll >= 3 || board.fill > 300) begin
            r.cell_x = 16'(int'($urandom_range(3)) - 1);
            r.cell_y = 16'(int'($urandom_range(3)) - 1);
            r.cell_z = 16'(int'($urandom_range(3)) - 1);
         end
         roll = $urandom_range(99);
         if (roll < 10) r.cell_count = '0;
         else if (roll < 60) r.cell_count = 24'($urandom_range(1, 1000));
      end else if (roll >= 12) begin
         r.point_x = 32'(board.origin[0] + int'($urandom_range(327680)) - 131072);
         r.point_y = 32'(board.origin[1] + int'($urandom_range(327680)) - 131072);
         r.point_z = 32'(board.origin[2] + int'($urandom_range(327680)) - 131072);
      end
      return r;
   endfunction

   initial begin
      board = new();
      cycles = 0;
      steady = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_ch.valid = 1'b0;
      csr_ch.payload = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset settings: added cells, an overwrite, a
      // zero count, the extreme cell indices and queries at exact grid
      // points, on negative fractions and at the edge of the cell range.
      load_cell(0, 0, 0, 100);
      load_cell(1, 0, 0, 200);
      load_cell(0, 1, 0, 24'hFFFFFF);
      load_cell(0, 0, 0, 50);
      load_cell(1, 1, 1, 0);
      load_cell(32767, 32767, 32767, 5);
      load_cell(-32768, -32768, -32768, 7);
      query_point(32'h8000, 32'h8000, 32'h8000);
      query_point(0, 0, 0);
      query_point(32'hFFFF_C000, 32'h4000, 32'hFFFF_0000);
      query_point(32'h7FFF_8000, 32'h7FFF_8000, 32'h7FFF_8000);
      query_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      query_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

      // One dimension: the y and z indices of a load do not enter the key.
      apply_setting(2'd1, 0, 0, 0, 32'd65536, 32'd65536, 32'd65536, 48'h1_0000_0000);
      load_cell(2, 123, -5, 900);
      query_point(32'h0001_8000, $urandom, $urandom);
      // Indexes past the register list must leave the settings alone.
      write_register(4'd9, 48'hFFFF_FFFF_FFFF);
      write_register(4'd15, 48'h1234);
      query_point(32'h0002_0000, $urandom, $urandom);

      // Random part, one phase per register setting, the extremes among them.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: apply_setting(2'd3, 0, 0, 0, 32'd65536, 32'd65536, 32'd65536,
                             48'h1_0000_0000);
            1: apply_setting(2'd2, 32'h8000, 32'hFFFE_8000, 5, 32'd131072, 32'd32768, 1,
                             48'hFFFF_FFFF_FFFF);
            2: apply_setting(2'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFF9,
                             32'd1, 32'd0, 32'd98304, 48'd12345678);
            3: apply_setting(2'd0, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF, 32'd65536,
                             32'd65536, 48'd0);
            default: apply_setting(2'd3, 32'hFFFF_FFF9, 3, 0, 32'd70000, 32'd65536,
                                   32'd0, 48'h3_0000_0000);
         endcase
         for (int n = 0; n < 180; n++) begin
            // The middle phase starts with a stretch without idles or stalls.
            steady = (phase == 2 && n < 100);
            // Once, the sender holds back until the block has caught up.
            if (phase == 1 && n == 90) wait_drained();
            send_request(random_request());
         end
         steady = 0;
      end

      // Fill the table to the brim with fresh cells, then hit the full case,
      // reload some cells and query among them with a full table.
      apply_setting(2'd3, 0, 0, 0, 32'd65536, 32'd65536, 32'd65536, 48'h1_0000_0000);
      for (int i = 0; board.fill < TABLE_ENTRIES; i++)
         load_cell(100 + i % 64, 100 + i / 64, -9, $urandom_range(1, 24'hFFFFFF));
      load_cell(500, 500, 500, 1);
      load_cell(-500, 7, 7, 2);
      load_cell(100, 100, -9, 0);
      load_cell(101, 100, -9, 42);
      query_point(32'h0064_8000, 32'h0064_8000, 32'hFFF7_8000);
      query_point(32'h0065_0000, 32'h0064_4000, 32'hFFF7_0000);
      load_cell(600, 600, 600, 3);

      wait_drained();
      repeat (50) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("** multilinear_binned_density_query: PASSED **");
      end else begin
         $display("** multilinear_binned_density_query: FAILED **");
      end
      $finish;
   end

endmodule
